FILE: rtl/sbfd_pkg.sv
// Shared widths, register indexes and reset values of the sliced black frame detector.
`default_nettype none

package sbfd_pkg;

   localparam int LUMA_W      = 8;
   localparam int COORD_W     = 12;
   localparam int ROW_HALF_W  = 6;
   localparam int LEFT_W      = 12;
   localparam int TOP_W       = 12;
   localparam int WIDTH_W     = 13;
   localparam int HEIGHT_W    = 13;
   localparam int SLCNT_W     = 5;
   localparam int STEP_W      = 3;
   localparam int THR_W       = 16;
   localparam int ENERGY_W    = 40;
   localparam int PHASE_W     = 3;
   localparam int SLICE_NUM_W = 5;
   localparam int SQ_W        = 16;
   localparam int Q_SHIFT     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] REG_ROI_LEFT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROI_TOP       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROI_WIDTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROI_HEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SLICE_COUNT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_STEP     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RMS_THRESHOLD = 3'd6;

   localparam logic [LEFT_W-1:0]   ROI_LEFT_RST      = 12'd0;
   localparam logic [TOP_W-1:0]    ROI_TOP_RST       = 12'd0;
   localparam logic [WIDTH_W-1:0]  ROI_WIDTH_RST     = 13'd1920;
   localparam logic [HEIGHT_W-1:0] ROI_HEIGHT_RST    = 13'd1080;
   localparam logic [SLCNT_W-1:0]  SLICE_COUNT_RST   = 5'd1;
   localparam logic [STEP_W-1:0]   LINE_STEP_RST     = 3'd1;
   localparam logic [THR_W-1:0]    RMS_THRESHOLD_RST = 16'd2560;

endpackage

`default_nettype wire

FILE: rtl/sbfd_ifs.sv
// Valid/ready channel interfaces for pixel requests, results and register writes.
`default_nettype none

interface sbfd_req_if;
   logic                             valid;
   logic                             ready;
   logic [sbfd_pkg::LUMA_W-1:0]      luma;
   logic [sbfd_pkg::COORD_W-1:0]     pixel_col;
   logic [sbfd_pkg::COORD_W-1:0]     pixel_row;
   logic                             frame_end;

   modport source (output valid, luma, pixel_col, pixel_row, frame_end, input ready);
   modport sink (input valid, luma, pixel_col, pixel_row, frame_end, output ready);
endinterface

interface sbfd_rsp_if;
   logic valid;
   logic ready;
   logic is_black;

   modport source (output valid, is_black, input ready);
   modport sink (input valid, is_black, output ready);
endinterface

interface sbfd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sbfd_pkg::CSR_IDX_W-1:0]    index;
   logic [sbfd_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sliced_black_frame_detect_core.sv
// Sliced black frame detector: four-stage pixel pipeline with a setup sequencer.
// Throughput is one pixel request per cycle when not stalled by a held result; a frame-end
// request passes the p1 to p4 registers and its result is held in an output register.
// After reset and after every register write a setup pass runs the shared divider
// and the multipliers; requests are not taken until it finishes.
`default_nettype none

module sliced_black_frame_detect_core #(
   parameter int MAX_DIM       = 4096,
   parameter int MAX_SLICES    = 16,
   parameter int MAX_LINE_STEP = 6
) (
   input  logic         clock,
   input  logic         reset,
   sbfd_req_if.sink     req_if,
   sbfd_rsp_if.source   rsp_if,
   sbfd_csr_if.sink     csr_if
);

   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int SL_W    = $clog2(MAX_SLICES + 1);
   localparam int SI_W    = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
   localparam int ST_W    = $clog2(MAX_LINE_STEP + 1);
   localparam int CNT_W   = 2 * DIM_W;
   localparam int CLO_W   = CNT_W / 2;
   localparam int CHI_W   = CNT_W - CLO_W;
   localparam int T2_W    = 2 * sbfd_pkg::THR_W;
   localparam int TC_W    = T2_W + CNT_W;
   localparam int BND_W   = DIM_W + SL_W;
   localparam int X_W     = (DIM_W > sbfd_pkg::COORD_W) ? DIM_W : sbfd_pkg::COORD_W;
   localparam int EQ_W    = sbfd_pkg::ENERGY_W + sbfd_pkg::Q_SHIFT;
   localparam int CMP_W   = (EQ_W > TC_W) ? EQ_W : TC_W;
   localparam int SEQ_N   = (DIM_W > MAX_SLICES) ? DIM_W : MAX_SLICES;
   localparam int SEQ_W   = $clog2(SEQ_N + 1);

   localparam logic [3:0] SQ_LOAD   = 4'd0;
   localparam logic [3:0] SQ_DIV_HS = 4'd1;
   localparam logic [3:0] SQ_DIV_N  = 4'd2;
   localparam logic [3:0] SQ_PHASE  = 4'd3;
   localparam logic [3:0] SQ_BND    = 4'd4;
   localparam logic [3:0] SQ_MUL    = 4'd5;
   localparam logic [3:0] SQ_TC_LO  = 4'd6;
   localparam logic [3:0] SQ_TC_HI  = 4'd7;
   localparam logic [3:0] SQ_SUM    = 4'd8;
   localparam logic [3:0] SQ_DONE   = 4'd9;

   function automatic logic [ST_W-1:0] mod_fold(
      input logic [ST_W-1:0]                   rem_i,
      input logic [sbfd_pkg::ROW_HALF_W-1:0]   bits_i,
      input logic [ST_W-1:0]                   den_i
   );
      logic [ST_W:0]   trial;
      logic [ST_W-1:0] rem;
      rem = rem_i;
      for (int i = sbfd_pkg::ROW_HALF_W - 1; i >= 0; i--) begin
         trial = {rem, bits_i[i]};
         if (trial >= {1'b0, den_i}) begin
            trial = trial - {1'b0, den_i};
         end
         rem = trial[ST_W-1:0];
      end
      return rem;
   endfunction

   // Configuration registers.
   logic [sbfd_pkg::LEFT_W-1:0]   roi_left_ff;
   logic [sbfd_pkg::TOP_W-1:0]    roi_top_ff;
   logic [sbfd_pkg::WIDTH_W-1:0]  roi_width_ff;
   logic [sbfd_pkg::HEIGHT_W-1:0] roi_height_ff;
   logic [sbfd_pkg::SLCNT_W-1:0]  slice_count_ff;
   logic [sbfd_pkg::STEP_W-1:0]   line_step_ff;
   logic [sbfd_pkg::THR_W-1:0]    rms_threshold_ff;
   logic                          csr_wr;

   assign csr_if.ready = 1'b1;
   assign csr_wr       = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         roi_left_ff      <= sbfd_pkg::ROI_LEFT_RST;
         roi_top_ff       <= sbfd_pkg::ROI_TOP_RST;
         roi_width_ff     <= sbfd_pkg::ROI_WIDTH_RST;
         roi_height_ff    <= sbfd_pkg::ROI_HEIGHT_RST;
         slice_count_ff   <= sbfd_pkg::SLICE_COUNT_RST;
         line_step_ff     <= sbfd_pkg::LINE_STEP_RST;
         rms_threshold_ff <= sbfd_pkg::RMS_THRESHOLD_RST;
      end else if (csr_wr) begin
         case (csr_if.index)
            sbfd_pkg::REG_ROI_LEFT:      roi_left_ff      <= csr_if.data[sbfd_pkg::LEFT_W-1:0];
            sbfd_pkg::REG_ROI_TOP:       roi_top_ff       <= csr_if.data[sbfd_pkg::TOP_W-1:0];
            sbfd_pkg::REG_ROI_WIDTH:     roi_width_ff     <= csr_if.data[sbfd_pkg::WIDTH_W-1:0];
            sbfd_pkg::REG_ROI_HEIGHT:    roi_height_ff    <= csr_if.data[sbfd_pkg::HEIGHT_W-1:0];
            sbfd_pkg::REG_SLICE_COUNT:   slice_count_ff   <= csr_if.data[sbfd_pkg::SLCNT_W-1:0];
            sbfd_pkg::REG_LINE_STEP:     line_step_ff     <= csr_if.data[sbfd_pkg::STEP_W-1:0];
            sbfd_pkg::REG_RMS_THRESHOLD: rms_threshold_ff <= csr_if.data[sbfd_pkg::THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamped register values.
   logic [DIM_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [SL_W-1:0]  slices_eff;
   logic [ST_W-1:0]  step_eff;

   assign w_eff = (32'(roi_width_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(roi_width_ff);
   assign h_eff = (32'(roi_height_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(roi_height_ff);
   assign slices_eff = (slice_count_ff == '0) ? SL_W'(1) :
                       (32'(slice_count_ff) > MAX_SLICES) ? SL_W'(MAX_SLICES) :
                       SL_W'(slice_count_ff);
   assign step_eff = (line_step_ff == '0) ? ST_W'(1) :
                     (32'(line_step_ff) > MAX_LINE_STEP) ? ST_W'(MAX_LINE_STEP) :
                     ST_W'(line_step_ff);

   // Setup sequencer with a shared restoring divider.
   logic [3:0]             seq_ff;
   logic [SEQ_W-1:0]       cnt_ff;
   logic [DIM_W-1:0]       div_quo_ff;
   logic [DIM_W-1:0]       div_rem_ff;
   logic [DIM_W-1:0]       div_den_ff;
   logic [DIM_W-1:0]       hs_ff;
   logic [DIM_W-1:0]       n_ff;
   logic [DIM_W-1:0]       limit_ff;
   logic [DIM_W-1:0]       nstep_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [T2_W-1:0]        t2_ff;
   logic [T2_W+CLO_W-1:0]  tc_lo_ff;
   logic [T2_W+CHI_W-1:0]  tc_hi_ff;
   logic [TC_W-1:0]        tc_ff;
   logic [BND_W-1:0]       bnd_acc_ff;
   logic [BND_W-1:0]       bnd_ff [MAX_SLICES];

   logic [DIM_W:0]         div_trial;
   logic                   div_ge;
   logic [DIM_W-1:0]       div_rem_in;
   logic [DIM_W-1:0]       div_quo_in;
   logic                   div_last;
   logic [DIM_W+ST_W-1:0]  nstep_full;
   logic [DIM_W+SL_W-1:0]  limit_full;
   logic [T2_W+CLO_W-1:0]  tc_lo_in;
   logic [T2_W+CHI_W-1:0]  tc_hi_in;
   logic                   busy;
   logic [sbfd_pkg::PHASE_W-1:0] phase_ff;
   logic                   phase_big;

   assign div_trial  = {div_rem_ff, div_quo_ff[DIM_W-1]};
   assign div_ge     = div_trial >= {1'b0, div_den_ff};
   assign div_rem_in = div_ge ? DIM_W'(div_trial - {1'b0, div_den_ff}) : DIM_W'(div_trial);
   assign div_quo_in = {div_quo_ff[DIM_W-2:0], div_ge};
   assign div_last   = cnt_ff == SEQ_W'(DIM_W - 1);
   assign nstep_full = (DIM_W+ST_W)'(n_ff) * (DIM_W+ST_W)'(step_eff);
   assign limit_full = (DIM_W+SL_W)'(hs_ff) * (DIM_W+SL_W)'(slices_eff);
   assign tc_lo_in   = (T2_W+CLO_W)'(t2_ff) * (T2_W+CLO_W)'(count_ff[CLO_W-1:0]);
   assign tc_hi_in   = (T2_W+CHI_W)'(t2_ff) * (T2_W+CHI_W)'(count_ff[CNT_W-1:CLO_W]);
   assign busy       = seq_ff != SQ_DONE;
   assign phase_big  = 32'(phase_ff) >= 32'(step_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SQ_LOAD;
         cnt_ff <= '0;
      end else if (csr_wr) begin
         seq_ff <= SQ_LOAD;
      end else begin
         case (seq_ff)
            SQ_LOAD: begin
               div_quo_ff <= h_eff;
               div_rem_ff <= '0;
               div_den_ff <= DIM_W'(slices_eff);
               cnt_ff     <= '0;
               seq_ff     <= SQ_DIV_HS;
            end
            SQ_DIV_HS: begin
               div_quo_ff <= div_quo_in;
               div_rem_ff <= div_rem_in;
               cnt_ff     <= cnt_ff + 1'b1;
               if (div_last) begin
                  hs_ff      <= div_quo_in;
                  div_rem_ff <= '0;
                  div_den_ff <= DIM_W'(step_eff);
                  cnt_ff     <= '0;
                  seq_ff     <= SQ_DIV_N;
               end
            end
            SQ_DIV_N: begin
               div_quo_ff <= div_quo_in;
               div_rem_ff <= div_rem_in;
               cnt_ff     <= cnt_ff + 1'b1;
               if (div_last) begin
                  n_ff   <= div_quo_in;
                  seq_ff <= SQ_PHASE;
               end
            end
            SQ_PHASE: begin
               if (!phase_big) begin
                  cnt_ff     <= '0;
                  bnd_acc_ff <= '0;
                  seq_ff     <= SQ_BND;
               end
            end
            SQ_BND: begin
               bnd_ff[cnt_ff[SI_W-1:0]] <= bnd_acc_ff;
               bnd_acc_ff <= bnd_acc_ff + BND_W'(hs_ff);
               cnt_ff     <= cnt_ff + 1'b1;
               if (cnt_ff == SEQ_W'(MAX_SLICES - 1)) begin
                  seq_ff <= SQ_MUL;
               end
            end
            SQ_MUL: begin
               count_ff <= CNT_W'(w_eff) * CNT_W'(n_ff);
               t2_ff    <= T2_W'(rms_threshold_ff) * T2_W'(rms_threshold_ff);
               nstep_ff <= nstep_full[DIM_W-1:0];
               limit_ff <= limit_full[DIM_W-1:0];
               seq_ff   <= SQ_TC_LO;
            end
            SQ_TC_LO: begin
               tc_lo_ff <= tc_lo_in;
               seq_ff   <= SQ_TC_HI;
            end
            SQ_TC_HI: begin
               tc_hi_ff <= tc_hi_in;
               seq_ff   <= SQ_SUM;
            end
            SQ_SUM: begin
               tc_ff  <= TC_W'(tc_lo_ff) + (TC_W'(tc_hi_ff) << CLO_W);
               seq_ff <= SQ_DONE;
            end
            SQ_DONE: begin
            end
            default: seq_ff <= SQ_LOAD;
         endcase
      end
   end

   // Pixel pipeline.
   logic stall;
   logic en;
   logic req_acc;

   logic                          p1_valid_ff;
   logic [sbfd_pkg::LUMA_W-1:0]   p1_luma_ff;
   logic [sbfd_pkg::COORD_W-1:0]  p1_col_ff;
   logic [sbfd_pkg::COORD_W-1:0]  p1_row_ff;
   logic                          p1_fe_ff;

   logic                          p2_valid_ff;
   logic                          p2_fe_ff;
   logic                          p2_in_roi_ff;
   logic [SI_W-1:0]               p2_s_ff;
   logic [sbfd_pkg::COORD_W-1:0]  p2_rel_ff;
   logic [BND_W-1:0]              p2_base_ff;
   logic [sbfd_pkg::SQ_W-1:0]     p2_sq_ff;

   logic                          p3_valid_ff;
   logic                          p3_fe_ff;
   logic                          p3_in_roi_ff;
   logic [SI_W-1:0]               p3_s_ff;
   logic [sbfd_pkg::SQ_W-1:0]     p3_sq_ff;
   logic                          p3_r_lt_ff;
   logic [ST_W-1:0]               p3_rem_hi_ff;
   logic [sbfd_pkg::ROW_HALF_W-1:0] p3_r_lo_ff;

   logic                          p4_valid_ff;
   logic                          p4_fe_ff;
   logic                          p4_in_roi_ff;
   logic [SI_W-1:0]               p4_s_ff;
   logic [sbfd_pkg::SQ_W-1:0]     p4_sq_ff;
   logic                          p4_r_lt_ff;
   logic [ST_W-1:0]               p4_r_mod_ff;

   logic [sbfd_pkg::ENERGY_W-1:0]    energy_ff;
   logic [sbfd_pkg::SLICE_NUM_W-1:0] slice_ff;
   logic                             bright_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_is_black_ff;

   assign stall         = p4_valid_ff && p4_fe_ff && rsp_valid_ff && !rsp_if.ready;
   assign en            = !stall;
   assign req_if.ready  = !busy && en;
   assign req_acc       = req_if.valid && req_if.ready;

   // Stage one: region test, slice lookup and square.
   logic [sbfd_pkg::COORD_W-1:0] col_off;
   logic [sbfd_pkg::COORD_W-1:0] rel_in;
   logic                         in_roi_in;
   logic [SI_W-1:0]              s_in;
   logic [BND_W-1:0]             base_in;
   logic [sbfd_pkg::SQ_W-1:0]    sq_in;

   always_comb begin
      col_off   = p1_col_ff - roi_left_ff;
      rel_in    = p1_row_ff - roi_top_ff;
      in_roi_in = (hs_ff != '0) &&
                  (p1_col_ff >= roi_left_ff) && (X_W'(col_off) < X_W'(w_eff)) &&
                  (p1_row_ff >= roi_top_ff) && (X_W'(rel_in) < X_W'(limit_ff));
      s_in    = '0;
      base_in = '0;
      for (int k = 0; k < MAX_SLICES; k++) begin
         if (BND_W'(rel_in) >= bnd_ff[k]) begin
            s_in    = SI_W'(k);
            base_in = bnd_ff[k];
         end
      end
      sq_in = sbfd_pkg::SQ_W'(p1_luma_ff) * sbfd_pkg::SQ_W'(p1_luma_ff);
   end

   // Stage two: offset in the slice and upper half of its residue.
   logic [BND_W-1:0]              r_full;
   logic [sbfd_pkg::COORD_W-1:0]  r_in;
   logic                          r_lt_in;
   logic [ST_W-1:0]               rem_hi_in;

   assign r_full    = BND_W'(p2_rel_ff) - p2_base_ff;
   assign r_in      = r_full[sbfd_pkg::COORD_W-1:0];
   assign r_lt_in   = X_W'(r_in) < X_W'(nstep_ff);
   assign rem_hi_in = mod_fold('0, r_in[sbfd_pkg::COORD_W-1:sbfd_pkg::ROW_HALF_W], step_eff);

   // Stage three: lower half of the residue.
   logic [ST_W-1:0] r_mod_in;

   assign r_mod_in = mod_fold(p3_rem_hi_ff, p3_r_lo_ff, step_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= req_acc;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_luma_ff   <= req_if.luma;
         p1_col_ff    <= req_if.pixel_col;
         p1_row_ff    <= req_if.pixel_row;
         p1_fe_ff     <= req_if.frame_end;
         p2_fe_ff     <= p1_fe_ff;
         p2_in_roi_ff <= in_roi_in;
         p2_s_ff      <= s_in;
         p2_rel_ff    <= rel_in;
         p2_base_ff   <= base_in;
         p2_sq_ff     <= sq_in;
         p3_fe_ff     <= p2_fe_ff;
         p3_in_roi_ff <= p2_in_roi_ff;
         p3_s_ff      <= p2_s_ff;
         p3_sq_ff     <= p2_sq_ff;
         p3_r_lt_ff   <= r_lt_in;
         p3_rem_hi_ff <= rem_hi_in;
         p3_r_lo_ff   <= r_in[sbfd_pkg::ROW_HALF_W-1:0];
         p4_fe_ff     <= p3_fe_ff;
         p4_in_roi_ff <= p3_in_roi_ff;
         p4_s_ff      <= p3_s_ff;
         p4_sq_ff     <= p3_sq_ff;
         p4_r_lt_ff   <= p3_r_lt_ff;
         p4_r_mod_ff  <= r_mod_in;
      end
   end

   // Stage four: slice closing, accumulation and the frame result.
   logic                             close_old;
   logic                             ge_old;
   logic                             sample;
   logic [sbfd_pkg::ENERGY_W-1:0]    e_base;
   logic [sbfd_pkg::ENERGY_W:0]      e_sum;
   logic [sbfd_pkg::ENERGY_W-1:0]    e_new;
   logic                             bright_mid;
   logic                             bright_fin;
   logic                             push;
   logic [sbfd_pkg::ENERGY_W-1:0]    energy_in;
   logic [sbfd_pkg::SLICE_NUM_W-1:0] slice_in;
   logic                             bright_in;
   logic [sbfd_pkg::PHASE_W:0]       phase_inc;
   logic [sbfd_pkg::PHASE_W-1:0]     phase_in;
   logic                             rsp_valid_in;

   always_comb begin
      close_old  = p4_in_roi_ff && (32'(p4_s_ff) != 32'(slice_ff));
      ge_old     = (CMP_W'(energy_ff) << sbfd_pkg::Q_SHIFT) >= CMP_W'(tc_ff);
      sample     = p4_in_roi_ff && p4_r_lt_ff && (32'(p4_r_mod_ff) == 32'(phase_ff));
      e_base     = close_old ? '0 : energy_ff;
      e_sum      = {1'b0, e_base} + (sbfd_pkg::ENERGY_W+1)'(p4_sq_ff);
      e_new      = !sample ? e_base :
                   e_sum[sbfd_pkg::ENERGY_W] ? '1 : e_sum[sbfd_pkg::ENERGY_W-1:0];
      bright_mid = bright_ff || (close_old && ge_old);
      bright_fin = bright_mid ||
                   ((CMP_W'(e_new) << sbfd_pkg::Q_SHIFT) >= CMP_W'(tc_ff));
      push       = p4_valid_ff && p4_fe_ff && en;
      phase_inc  = {1'b0, phase_ff} + 1'b1;
      phase_in   = (32'(phase_inc) == 32'(step_eff)) ? '0 : phase_inc[sbfd_pkg::PHASE_W-1:0];

      energy_in = energy_ff;
      slice_in  = slice_ff;
      bright_in = bright_ff;
      if (p4_valid_ff && en) begin
         if (p4_fe_ff) begin
            energy_in = '0;
            slice_in  = '0;
            bright_in = 1'b0;
         end else begin
            energy_in = e_new;
            bright_in = bright_mid;
            if (p4_in_roi_ff) begin
               slice_in = sbfd_pkg::SLICE_NUM_W'(p4_s_ff);
            end
         end
      end

      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff    <= '0;
         slice_ff     <= '0;
         bright_ff    <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         energy_ff    <= energy_in;
         slice_ff     <= slice_in;
         bright_ff    <= bright_in;
         rsp_valid_ff <= rsp_valid_in;
         if (seq_ff == SQ_PHASE && phase_big) begin
            phase_ff <= phase_ff - sbfd_pkg::PHASE_W'(step_eff);
         end else if (push) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_is_black_ff <= !bright_fin;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.is_black = rsp_is_black_ff;

`ifndef SYNTH
   a_csr_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> !req_if.ready)
      else $error("A request was offered ready straight after a register write.");

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (32'(phase_ff) < 32'(step_eff)))
      else $error("The line phase is not below the line step after setup.");

   a_frame_state_cleared: assert property (@(posedge clock) disable iff (reset)
      push |=> (energy_ff == '0) && !bright_ff && (slice_ff == '0))
      else $error("The frame state was not cleared after a result.");

   a_result_from_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(p4_valid_ff && p4_fe_ff))
      else $error("A result appeared without a frame-end request.");
`endif

endmodule

`default_nettype wire
